// ===== rtl/core/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types and constants of the delay line pitch shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int EDGE_MARGIN = 12;
  localparam int ACC_W       = 64;

  localparam int RATE_W = 18;
  localparam int MIX_W  = 17;
  localparam int WRAP_W = 12;
  localparam int HALF_W = 11;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam cfg_index_t REG_SHIFT_RATE  = 2'd0;
  localparam cfg_index_t REG_EFFECT_MIX  = 2'd1;
  localparam cfg_index_t REG_WRAP_LENGTH = 2'd2;
  localparam cfg_index_t REG_HALF_LENGTH = 2'd3;

  localparam logic signed [ACC_W-1:0] HALF_Q16 = 64'sh0000_0000_0000_8000;
  localparam logic signed [ACC_W-1:0] HALF_Q32 = 64'sh0000_0000_8000_0000;

endpackage

// ===== rtl/core/delay_line_pitch_shifter.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Dual-tap crossfading delay line pitch shifter with one shared delay memory.
//
// Channel  Dir  Payload
// s_axis   in   tdata[15:0] = sample_in
// m_axis   out  tdata[15:0] = sample_out
// cfg      in   cfg_index, cfg_data = shift_rate, effect_mix, wrap_length,
//               half_length
//
// One item at a time. The sequencer waits on each division in the shared
// radix-2 divider, one for the envelope and up to four more when a tap leaves
// its range, and on the two shift-add products, which end once their remaining
// multiplier bits are zero. Reset needs no memory sweep; entries not yet
// written read as zero through a fill flag. A waiting result does not block
// the next item.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter #(
  parameter int DELAY_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  dlps_pkg::sample_t    s_axis_tdata,   // [15:0] sample_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output dlps_pkg::sample_t    m_axis_tdata,   // [15:0] sample_out
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dlps_pkg::cfg_index_t cfg_index,
  input  dlps_pkg::cfg_data_t  cfg_data
);

  import dlps_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int PIW = ((AW > 12) ? AW : 12) + 2;
  localparam int PW  = PIW + FRAC_BITS;
  localparam int SW  = PW + 1;
  localparam int IW  = SW - FRAC_BITS;

  localparam logic signed [SW-1:0] POS_HI =
    {1'b0, PIW'(DELAY_DEPTH - EDGE_MARGIN), {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] POS_LO =
    {1'b0, PIW'(EDGE_MARGIN), {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] POS_ONE = SW'(1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_FHI   = 5'd1;
  localparam logic [4:0] ST_FHIW  = 5'd2;
  localparam logic [4:0] ST_FLO   = 5'd3;
  localparam logic [4:0] ST_FLOW  = 5'd4;
  localparam logic [4:0] ST_FDONE = 5'd5;
  localparam logic [4:0] ST_ENV   = 5'd6;
  localparam logic [4:0] ST_ENVW  = 5'd7;
  localparam logic [4:0] ST_RD    = 5'd8;
  localparam logic [4:0] ST_TAP0  = 5'd9;
  localparam logic [4:0] ST_TAP1  = 5'd10;
  localparam logic [4:0] ST_DIFF  = 5'd11;
  localparam logic [4:0] ST_MAC0  = 5'd12;
  localparam logic [4:0] ST_ROUND = 5'd13;
  localparam logic [4:0] ST_MAC1  = 5'd14;
  localparam logic [4:0] ST_SAT   = 5'd15;

  logic [4:0] state;

  logic signed [RATE_W-1:0] shift_rate;
  logic [MIX_W-1:0]         effect_mix;
  logic [WRAP_W-1:0]        wrap_length;
  logic [HALF_W-1:0]        half_length;

  logic signed [SW-1:0]  tap_position;
  logic signed [SW-1:0]  pos;
  logic [FRAC_BITS-1:0]  efrac;
  logic                  fold_sel;
  logic [AW-1:0]         wp;
  logic                  full;
  sample_t               dry;
  logic [PW-1:0]         env1;
  sample_t               smp [4];
  logic [2:0]            rd_cnt;
  logic                  rd_ok;
  logic signed [35:0]    tap0;
  logic signed [35:0]    tap1;
  logic signed [35:0]    dryterm;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [SAMPLE_W-1:0]   ram_rdata;
  logic                  addr_ok;

  logic signed [SW-1:0]  wrap_q;
  logic signed [SW-1:0]  half_q;
  logic signed [SW-1:0]  hi_ex;
  logic signed [SW-1:0]  lo_ex;
  logic signed [SW-1:0]  rem_full;
  logic signed [IW-1:0]  hm;
  logic signed [SW-1:0]  num;
  logic signed [SW-1:0]  neg_num;
  logic [PW-1:0]         mag;
  logic [WRAP_W-1:0]     env_div;

  logic                  div_start;
  logic [PW-1:0]         div_dividend;
  logic [WRAP_W-1:0]     div_divisor;
  logic                  div_busy;
  logic                  div_done;
  logic [PW-1:0]         div_quo;
  logic [WRAP_W-1:0]     div_rem;

  logic [AW-1:0]         idx0;
  logic [AW-1:0]         idx1;
  logic [FRAC_BITS-1:0]  a0;
  logic [FRAC_BITS-1:0]  a1;

  logic signed [17:0]    mul_x;
  logic signed [17:0]    mul_y;
  logic signed [35:0]    mul_p;
  sample_t               tap_base;
  logic signed [35:0]    tap_val;
  logic signed [17:0]    dry_w;

  logic                    mac_start;
  logic signed [ACC_W-1:0] mac_init;
  logic signed [ACC_W-1:0] mac_mcand;
  logic [PW-1:0]           mac_mplier;
  logic                    mac_busy;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_acc;
  logic signed [ACC_W-1:0] wet_sum;
  logic signed [ACC_W-1:0] wet;
  logic signed [ACC_W-1:0] fin_sum;
  logic signed [31:0]      res_w;
  sample_t                 sat_val;
  logic                    out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign ram_we = s_axis_tvalid && s_axis_tready;

  dlps_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (s_axis_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wrap_q   = {{(IW - WRAP_W){1'b0}}, wrap_length, {FRAC_BITS{1'b0}}};
  assign half_q   = {{(IW - HALF_W){1'b0}}, half_length, {FRAC_BITS{1'b0}}};
  assign hi_ex    = pos - POS_HI - POS_ONE;
  assign lo_ex    = POS_LO - pos - POS_ONE;
  assign rem_full = {{(IW - WRAP_W){1'b0}}, div_rem, efrac};
  assign hm       = $signed({{(IW - HALF_W){1'b0}}, half_length}) - IW'(EDGE_MARGIN);
  assign num      = tap_position - $signed({hm, {FRAC_BITS{1'b0}}});
  assign neg_num  = -num;
  assign mag      = num[SW-1] ? neg_num[PW-1:0] : num[PW-1:0];
  assign env_div  = WRAP_W'(half_length) + WRAP_W'(EDGE_MARGIN);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag;
    div_divisor  = env_div;
    case (state)
      ST_FHI: begin
        if ((pos > POS_HI) && (wrap_length != '0)) begin
          div_start    = 1'b1;
          div_dividend = {{(PW - IW){1'b0}}, hi_ex[SW-1:FRAC_BITS]};
          div_divisor  = wrap_length;
        end
      end
      ST_FLO: begin
        if ((pos < POS_LO) && (wrap_length != '0)) begin
          div_start    = 1'b1;
          div_dividend = {{(PW - IW){1'b0}}, lo_ex[SW-1:FRAC_BITS]};
          div_divisor  = wrap_length;
        end
      end
      ST_ENV: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  dlps_div #(
    .DW (PW),
    .VW (WRAP_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign idx0 = wp - tap_position[AW+FRAC_BITS-1:FRAC_BITS]
              - AW'(|tap_position[FRAC_BITS-1:0]);
  assign idx1 = wp - pos[AW+FRAC_BITS-1:FRAC_BITS] - AW'(|pos[FRAC_BITS-1:0]);
  assign a0   = FRAC_BITS'(0) - tap_position[FRAC_BITS-1:0];
  assign a1   = FRAC_BITS'(0) - pos[FRAC_BITS-1:0];

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    ram_raddr = idx0;
      2'd1:    ram_raddr = idx0 + AW'(1);
      2'd2:    ram_raddr = idx1;
      default: ram_raddr = idx1 + AW'(1);
    endcase
  end

  assign addr_ok = full || (ram_raddr <= wp);

  assign dry_w = 18'sh10000 - $signed({1'b0, effect_mix});

  always_comb begin
    case (state)
      ST_TAP0: begin
        mul_x    = {{2{smp[1][15]}}, smp[1]} - {{2{smp[0][15]}}, smp[0]};
        mul_y    = {2'b00, a0};
        tap_base = smp[0];
      end
      ST_TAP1: begin
        mul_x    = {{2{smp[3][15]}}, smp[3]} - {{2{smp[2][15]}}, smp[2]};
        mul_y    = {2'b00, a1};
        tap_base = smp[2];
      end
      default: begin
        mul_x    = {{2{dry[15]}}, dry};
        mul_y    = dry_w;
        tap_base = dry;
      end
    endcase
  end

  assign mul_p   = mul_x * mul_y;
  assign tap_val = {{4{tap_base[15]}}, tap_base, {FRAC_BITS{1'b0}}} + mul_p;

  assign wet_sum = mac_acc + HALF_Q16;
  assign wet     = wet_sum >>> FRAC_BITS;
  assign fin_sum = mac_acc + HALF_Q32;
  assign res_w   = fin_sum[ACC_W-1:32];

  always_comb begin
    if (res_w > 32'sd32767) begin
      sat_val = 16'sh7FFF;
    end else if (res_w < -32'sd32768) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = res_w[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    mac_start  = 1'b0;
    mac_init   = ACC_W'(tap0) <<< FRAC_BITS;
    mac_mcand  = ACC_W'(tap1) - ACC_W'(tap0);
    mac_mplier = env1;
    case (state)
      ST_DIFF: begin
        mac_start = 1'b1;
      end
      ST_ROUND: begin
        mac_start  = 1'b1;
        mac_init   = ACC_W'(dryterm) <<< FRAC_BITS;
        mac_mcand  = wet;
        mac_mplier = PW'(effect_mix);
      end
      default: begin
      end
    endcase
  end

  dlps_mac #(
    .MW (PW)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .start    (mac_start),
    .acc_init (mac_init),
    .mcand    (mac_mcand),
    .mplier   (mac_mplier),
    .busy     (mac_busy),
    .done     (mac_done),
    .acc      (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      shift_rate    <= '0;
      effect_mix    <= MIX_W'(32768);
      wrap_length   <= WRAP_W'(4072);
      half_length   <= HALF_W'(2036);
      tap_position  <= POS_LO;
      wp            <= '0;
      full          <= 1'b0;
      fold_sel      <= 1'b0;
      rd_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHIFT_RATE:  shift_rate  <= cfg_data[RATE_W-1:0];
          REG_EFFECT_MIX:  effect_mix  <= cfg_data[MIX_W-1:0];
          REG_WRAP_LENGTH: wrap_length <= cfg_data[WRAP_W-1:0];
          REG_HALF_LENGTH: half_length <= cfg_data[HALF_W-1:0];
          default: begin
          end
        endcase
      end

      if ((state == ST_SAT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dry      <= s_axis_tdata;
            pos      <= tap_position + SW'(shift_rate);
            fold_sel <= 1'b0;
            state    <= ST_FHI;
          end
        end
        ST_FHI: begin
          if (pos > POS_HI) begin
            if (wrap_length == '0) begin
              pos   <= POS_HI;
              state <= ST_FDONE;
            end else begin
              efrac <= hi_ex[FRAC_BITS-1:0];
              state <= ST_FHIW;
            end
          end else begin
            state <= ST_FLO;
          end
        end
        ST_FHIW: begin
          if (div_done) begin
            pos   <= POS_HI + POS_ONE - wrap_q + rem_full;
            state <= ST_FLO;
          end
        end
        ST_FLO: begin
          if (pos < POS_LO) begin
            if (wrap_length == '0) begin
              pos   <= POS_LO;
              state <= ST_FDONE;
            end else begin
              efrac <= lo_ex[FRAC_BITS-1:0];
              state <= ST_FLOW;
            end
          end else begin
            state <= ST_FDONE;
          end
        end
        ST_FLOW: begin
          if (div_done) begin
            pos   <= POS_LO - POS_ONE + wrap_q - rem_full;
            state <= ST_FDONE;
          end
        end
        ST_FDONE: begin
          if (!fold_sel) begin
            tap_position <= pos;
            pos          <= pos + half_q;
            fold_sel     <= 1'b1;
            state        <= ST_FHI;
          end else begin
            state <= ST_ENV;
          end
        end
        ST_ENV: begin
          state <= ST_ENVW;
        end
        ST_ENVW: begin
          if (div_done) begin
            env1   <= div_quo;
            rd_cnt <= '0;
            state  <= ST_RD;
          end
        end
        ST_RD: begin
          rd_cnt <= rd_cnt + 3'd1;
          rd_ok  <= addr_ok;
          if (rd_cnt != 3'd0) begin
            smp[2'(rd_cnt[1:0] - 2'd1)] <= rd_ok ? ram_rdata : '0;
          end
          if (rd_cnt == 3'd4) begin
            state <= ST_TAP0;
          end
        end
        ST_TAP0: begin
          tap0  <= tap_val;
          state <= ST_TAP1;
        end
        ST_TAP1: begin
          tap1  <= tap_val;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          dryterm <= mul_p;
          state   <= ST_MAC0;
        end
        ST_MAC0: begin
          if (mac_done) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state <= ST_MAC1;
        end
        ST_MAC1: begin
          if (mac_done) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (out_free) begin
            m_axis_tdata <= sat_val;
            wp           <= wp + AW'(1);
            if (wp == {AW{1'b1}}) begin
              full <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (!div_busy && !mac_busy))
    else $error("Item accepted while an arithmetic unit is still running.");

  assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("Divider restarted while busy.");

  assert property (@(posedge clk) disable iff (rst)
    mac_start |-> !mac_busy)
    else $error("Multiply-accumulate restarted while busy.");

  assert property (@(posedge clk) disable iff (rst)
    tap_position >= POS_LO)
    else $error("Tap position fell below its lower bound.");

endmodule

// ===== rtl/core/dlps_ram.sv =====
// ----------------------------------------------------------------------------
// dlps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dlps_div.sv =====
// ----------------------------------------------------------------------------
// dlps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlps_div #(
  parameter int DW = 30,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   partial;
  logic [VW:0]   diff;
  logic          fits;

  assign partial = {remainder, quotient[DW-1]};
  assign diff    = partial - {1'b0, dvs};
  assign fits    = partial >= {1'b0, dvs};
  assign busy    = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run       <= 1'b1;
        cnt       <= CW'(DW);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (run) begin
        remainder <= fits ? diff[VW-1:0] : partial[VW-1:0];
        quotient  <= {quotient[DW-2:0], fits};
        cnt       <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/dlps_mac.sv =====
// ----------------------------------------------------------------------------
// dlps_mac
// Shift-add multiply-accumulate: acc = init + mcand * mplier, one multiplier
// bit per cycle, finishing as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module dlps_mac #(
  parameter int MW = 30
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [dlps_pkg::ACC_W-1:0]  acc_init,
  input  logic signed [dlps_pkg::ACC_W-1:0]  mcand,
  input  logic [MW-1:0]                      mplier,
  output logic                               busy,
  output logic                               done,
  output logic signed [dlps_pkg::ACC_W-1:0]  acc
);

  import dlps_pkg::*;

  logic                    run;
  logic signed [ACC_W-1:0] mc;
  logic [MW-1:0]           mp;

  assign busy = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (mp == '0);
      if (start) begin
        run <= 1'b1;
        acc <= acc_init;
        mc  <= mcand;
        mp  <= mplier;
      end else if (run) begin
        if (mp == '0) begin
          run <= 1'b0;
        end else begin
          if (mp[0]) begin
            acc <= acc + mc;
          end
          mc <= mc <<< 1;
          mp <= mp >> 1;
        end
      end
    end
  end

endmodule
